FILE: rtl/qsl_pkg.sv
// ----------------------------------------------------------------------------
// qsl_pkg
// Shared types and constants for the quicksort (Lomuto partition) sorter.
// ----------------------------------------------------------------------------
package qsl_pkg;

  localparam int MAX_ELEMENTS = 64;
  localparam int STACK_DEPTH  = 64;
  localparam int DATA_W       = 64;
  localparam int IDX_W        = $clog2(MAX_ELEMENTS);
  localparam int CNT_W        = IDX_W + 1;
  localparam int SP_W         = $clog2(STACK_DEPTH) + 1;
  localparam int RANGE_W      = 2 * IDX_W;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     last;
  } in_word_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] sorted_value;
    logic                     final_res;
  } out_word_t;

endpackage

FILE: rtl/qsl_ram.sv
// ----------------------------------------------------------------------------
// qsl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module qsl_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/quicksort_lomuto_sorter_core.sv
// ----------------------------------------------------------------------------
// quicksort_lomuto_sorter_core
// Collects signed words, sorts them by quicksort with Lomuto partitioning
// using an explicit range stack, then streams them out in ascending order.
// ----------------------------------------------------------------------------
// Load: one word per cycle, busy stays low until a word with last set.
// Sort: per partition of a range of m words, each scanned word is read and
//   compared, each word at or below the pivot is swapped, plus pop/pivot/fix-up;
//   one store port and one 64-bit compare serialise these (O(n log n) on average).
// Output: one result per cycle, n results, streamed once the sort is done;
//   the receiver cannot stall. Reset clears count, stack pointer, sequencer.
module quicksort_lomuto_sorter_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  qsl_pkg::in_word_t   item,
  output logic                strobe,
  output qsl_pkg::out_word_t  result
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_INIT  = 4'd1;
  localparam logic [3:0] S_POP   = 4'd2;
  localparam logic [3:0] S_POPW  = 4'd3;
  localparam logic [3:0] S_PIV   = 4'd4;
  localparam logic [3:0] S_SCAN  = 4'd5;
  localparam logic [3:0] S_CMP   = 4'd6;
  localparam logic [3:0] S_SWA   = 4'd7;
  localparam logic [3:0] S_SWB   = 4'd8;
  localparam logic [3:0] S_FINA  = 4'd9;
  localparam logic [3:0] S_FINB  = 4'd10;
  localparam logic [3:0] S_PUSHR = 4'd11;
  localparam logic [3:0] S_OUT   = 4'd12;

  localparam int IW = qsl_pkg::IDX_W;
  localparam int CW = qsl_pkg::CNT_W;
  localparam int SW = qsl_pkg::SP_W;
  localparam int DW = qsl_pkg::DATA_W;
  localparam int RW = qsl_pkg::RANGE_W;
  localparam int SAW = SW - 1;

  logic [3:0]    state;
  logic [CW-1:0] count;
  logic [SW-1:0] sp;
  logic [IW-1:0] lo, hi, i, p, k;
  logic [DW-1:0] pivot, held, tmp;
  logic          final_flag;

  logic          st_we;
  logic [IW-1:0] st_waddr, st_raddr;
  logic [DW-1:0] st_wdata, st_rdata;
  logic          sk_we;
  logic [SAW-1:0] sk_waddr, sk_raddr;
  logic [RW-1:0] sk_wdata, sk_rdata;

  logic          store_ok;
  logic          stack_ok;
  logic [SW-1:0] sp_dec;
  logic          scan_more;
  logic          le_pivot;
  logic          push_left, push_right;
  logic [IW-1:0] pop_lo, pop_hi;
  logic          out_last;

  assign store_ok   = count < CW'(qsl_pkg::MAX_ELEMENTS);
  assign stack_ok   = sp < SW'(qsl_pkg::STACK_DEPTH);
  assign sp_dec     = sp - SW'(1);
  assign scan_more  = i < hi;
  // the single compare unit
  assign le_pivot   = $signed(st_rdata) <= $signed(pivot);
  assign push_left  = {1'b0, p} > ({1'b0, lo} + CW'(1));
  assign push_right = ({1'b0, p} + CW'(1)) < {1'b0, hi};
  assign pop_lo     = sk_rdata[RW-1:IW];
  assign pop_hi     = sk_rdata[IW-1:0];
  assign out_last   = {1'b0, k} == (count - CW'(1));

  always_comb begin
    st_we    = 1'b0;
    st_waddr = p;
    st_wdata = tmp;
    st_raddr = i;
    sk_we    = 1'b0;
    sk_waddr = sp[SAW-1:0];
    sk_wdata = {lo, hi};
    sk_raddr = sp_dec[SAW-1:0];
    case (state)
      S_IDLE: begin
        st_we    = start && store_ok;
        st_waddr = count[IW-1:0];
        st_wdata = item.value;
      end
      S_INIT: begin
        sk_we    = count >= CW'(2);
        sk_waddr = '0;
        sk_wdata = {IW'(0), IW'(count - CW'(1))};
      end
      S_POPW: st_raddr = pop_hi;
      S_SCAN: st_raddr = scan_more ? i : p;
      S_CMP:  st_raddr = p;
      S_SWA: begin
        st_we    = 1'b1;
        st_waddr = p;
        st_wdata = held;
      end
      S_SWB: begin
        st_we    = 1'b1;
        st_waddr = i;
        st_wdata = tmp;
      end
      S_FINA: begin
        st_we    = 1'b1;
        st_waddr = p;
        st_wdata = pivot;
      end
      S_FINB: begin
        st_we    = 1'b1;
        st_waddr = hi;
        st_wdata = tmp;
        sk_we    = push_left && stack_ok;
        sk_wdata = {lo, p - IW'(1)};
      end
      S_PUSHR: begin
        sk_we    = push_right && stack_ok;
        sk_wdata = {p + IW'(1), hi};
      end
      S_OUT: st_raddr = k;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      sp         <= '0;
      strobe     <= 1'b0;
      final_flag <= 1'b0;
    end else begin
      strobe <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            if (store_ok) begin
              count <= count + CW'(1);
            end
            if (item.last) begin
              state <= S_INIT;
            end
          end
        end
        S_INIT: begin
          sp    <= (count >= CW'(2)) ? SW'(1) : SW'(0);
          state <= S_POP;
        end
        S_POP: begin
          if (sp == '0) begin
            k     <= '0;
            state <= S_OUT;
          end else begin
            sp    <= sp_dec;
            state <= S_POPW;
          end
        end
        S_POPW: begin
          lo    <= pop_lo;
          hi    <= pop_hi;
          state <= (pop_lo >= pop_hi) ? S_POP : S_PIV;
        end
        S_PIV: begin
          pivot <= st_rdata;
          i     <= lo;
          p     <= lo;
          state <= S_SCAN;
        end
        S_SCAN: state <= scan_more ? S_CMP : S_FINA;
        S_CMP: begin
          held <= st_rdata;
          if (le_pivot) begin
            state <= S_SWA;
          end else begin
            i     <= i + IW'(1);
            state <= S_SCAN;
          end
        end
        S_SWA: begin
          tmp   <= st_rdata;
          state <= S_SWB;
        end
        S_SWB: begin
          i     <= i + IW'(1);
          p     <= p + IW'(1);
          state <= S_SCAN;
        end
        S_FINA: begin
          tmp   <= st_rdata;
          state <= S_FINB;
        end
        S_FINB: begin
          if (push_left && stack_ok) begin
            sp <= sp + SW'(1);
          end
          state <= S_PUSHR;
        end
        S_PUSHR: begin
          if (push_right && stack_ok) begin
            sp <= sp + SW'(1);
          end
          state <= S_POP;
        end
        S_OUT: begin
          if (count == '0) begin
            state <= S_IDLE;
          end else begin
            strobe     <= 1'b1;
            final_flag <= out_last;
            k          <= k + IW'(1);
            if (out_last) begin
              count <= '0;
              sp    <= '0;
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign busy                = state != S_IDLE;
  assign result.sorted_value = st_rdata;
  assign result.final_res    = final_flag;

  qsl_ram #(
    .WIDTH(DW),
    .DEPTH(qsl_pkg::MAX_ELEMENTS)
  ) u_store (
    .clk  (clk),
    .we   (st_we),
    .waddr(st_waddr),
    .wdata(st_wdata),
    .raddr(st_raddr),
    .rdata(st_rdata)
  );

  qsl_ram #(
    .WIDTH(RW),
    .DEPTH(qsl_pkg::STACK_DEPTH)
  ) u_stack (
    .clk  (clk),
    .we   (sk_we),
    .waddr(sk_waddr),
    .wdata(sk_wdata),
    .raddr(sk_raddr),
    .rdata(sk_rdata)
  );

endmodule

FILE: rtl/qsl_checker.sv
// ----------------------------------------------------------------------------
// qsl_checker
// Port-level checks of the sorter's command and result sequencing.
// ----------------------------------------------------------------------------
module qsl_checker (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input qsl_pkg::in_word_t  item,
  input logic               strobe,
  input qsl_pkg::out_word_t result
);

  // results only come out of a running sort
  a_strobe_after_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(busy))
    else $error("result word without a sort in progress");

  // a plain load word leaves the block ready
  a_load_stays_ready: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !item.last) |=> !busy)
    else $error("busy after a non-final word");

  // the final input word starts the sort
  a_last_starts_sort: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && item.last) |=> busy)
    else $error("sort did not start on final word");

  // nothing follows the final result of a run
  a_final_ends_run: assert property (@(posedge clk) disable iff (rst)
    (strobe && result.final_res) |=> !strobe)
    else $error("result word after the final one");

endmodule

bind quicksort_lomuto_sorter_core qsl_checker u_qsl_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .item  (item),
  .strobe(strobe),
  .result(result)
);
